>>> hw/rtl/c128_pkg.sv
// ----------------------------------------------------------------------------
// c128_pkg
// Shared types, constants and the symbol width table of the Code 128 set B
// module encoder.
// ----------------------------------------------------------------------------
package c128_pkg;

    localparam int unsigned SYMBOL_COUNT = 106;
    localparam int unsigned CHECK_MOD    = 103;
    localparam int unsigned CODE_OFFSET  = 32;
    localparam int unsigned START_B      = 104;

    localparam logic [7:0]  CODE_LOW       = 8'(CODE_OFFSET);
    localparam logic [7:0]  CODE_HIGH      = 8'(CODE_OFFSET + SYMBOL_COUNT - 1);
    localparam logic [6:0]  START_VALUE    = 7'(START_B);
    localparam logic [6:0]  CHECK_INIT     = 7'(START_B % CHECK_MOD);
    localparam logic [6:0]  POS_LAST       = 7'(CHECK_MOD - 1);
    localparam logic [7:0]  CHECK_MOD_W    = 8'(CHECK_MOD);
    // floor(2^16 / 103), kept below the true reciprocal so the quotient
    // estimate is never too large
    localparam logic [9:0]  RECIP_103      = 10'((1 << 16) / CHECK_MOD);
    localparam logic [12:0] STOP_PATTERN   = 13'h18EB;
    localparam logic [3:0]  STOP_MODULES   = 4'd13;
    localparam logic [3:0]  SYMBOL_MODULES = 4'd11;

    typedef enum logic [2:0] {
        KIND_START  = 3'd0,
        KIND_DATA   = 3'd1,
        KIND_CHECK  = 3'd2,
        KIND_STOP   = 3'd3,
        KIND_REJECT = 3'd4
    } t_kind;

    // Decoded request handed from the front end to the result sequencer.
    typedef struct packed {
        logic       need_start;
        t_kind      main_kind;
        logic [6:0] main_value;
        logic       has_stop;
    } t_item;

    // Bar/space widths, one octal digit per element, bar first.
    localparam logic [17:0] WIDTHS [SYMBOL_COUNT] = '{
        18'o212222, 18'o222122, 18'o222221, 18'o121223, 18'o121322,
        18'o131222, 18'o122213, 18'o122312, 18'o132212, 18'o221213,
        18'o221312, 18'o231212, 18'o112232, 18'o122132, 18'o122231,
        18'o113222, 18'o123122, 18'o123221, 18'o223211, 18'o221132,
        18'o221231, 18'o213212, 18'o223112, 18'o312131, 18'o311222,
        18'o321122, 18'o321221, 18'o312212, 18'o322112, 18'o322211,
        18'o212123, 18'o212321, 18'o232121, 18'o111323, 18'o131123,
        18'o131321, 18'o112313, 18'o132113, 18'o132311, 18'o211313,
        18'o231113, 18'o231311, 18'o112133, 18'o112331, 18'o132131,
        18'o113123, 18'o113321, 18'o133121, 18'o313121, 18'o211331,
        18'o231131, 18'o213113, 18'o213311, 18'o213131, 18'o311123,
        18'o311321, 18'o331121, 18'o312113, 18'o312311, 18'o332111,
        18'o314111, 18'o221411, 18'o431111, 18'o111224, 18'o111422,
        18'o121124, 18'o121421, 18'o141122, 18'o141221, 18'o112214,
        18'o112412, 18'o122114, 18'o122411, 18'o142112, 18'o142211,
        18'o241211, 18'o221114, 18'o413111, 18'o241112, 18'o134111,
        18'o111242, 18'o121142, 18'o121241, 18'o114212, 18'o124112,
        18'o124211, 18'o411212, 18'o421112, 18'o421211, 18'o212141,
        18'o214121, 18'o412121, 18'o111143, 18'o111341, 18'o131141,
        18'o114113, 18'o114311, 18'o411113, 18'o411311, 18'o113141,
        18'o114131, 18'o311141, 18'o411131, 18'o211412, 18'o211214,
        18'o211232
    };

    // Expand a symbol value into its 11 modules, first module in bit 10.
    function automatic logic [10:0] symbol_pattern(input logic [6:0] value);
        logic [17:0] w;
        logic [10:0] bits;
        logic [2:0]  n;
        w    = (value < 7'(SYMBOL_COUNT)) ? WIDTHS[value] : '0;
        bits = '0;
        for (int i = 0; i < 6; i++) begin
            n    = w[17 - 3 * i -: 3];
            bits = bits << n;
            if ((i & 1) == 0) begin
                bits = bits | 11'((12'd1 << n) - 12'd1);
            end
        end
        return bits;
    endfunction

endpackage

>>> hw/rtl/c128_check.sv
// ----------------------------------------------------------------------------
// c128_check
// Weighted check sum: position counter, value * position product register
// and a modulo-103 fold of the pending product into the running sum.
// ----------------------------------------------------------------------------
module c128_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_data_acc,
    input  logic       i_end_acc,
    input  logic [6:0] i_value,
    output logic [6:0] o_check
);
    import c128_pkg::*;

    logic [6:0]  r_pos;
    logic [6:0]  n_pos;
    logic [13:0] r_prod;
    logic [13:0] n_prod;
    logic [6:0]  r_check;
    logic [13:0] w_sum;
    logic [23:0] w_scaled;
    logic [6:0]  w_quot;
    logic [13:0] w_rem_full;
    logic [7:0]  w_rem;
    logic [6:0]  w_fold;

    assign n_pos  = (r_pos == POS_LAST) ? 7'd0 : r_pos + 7'd1;
    assign n_prod = 14'(i_value) * 14'(n_pos);

    // fold the product of the last accepted character into the sum
    assign w_sum      = 14'(r_check) + r_prod;
    assign w_scaled   = 24'(w_sum) * 24'(RECIP_103);
    assign w_quot     = w_scaled[22:16];
    assign w_rem_full = w_sum - 14'(w_quot) * 14'(CHECK_MOD_W);
    assign w_rem      = w_rem_full[7:0];
    assign w_fold     = (w_rem >= CHECK_MOD_W) ? 7'(w_rem - CHECK_MOD_W) : w_rem[6:0];

    assign o_check = w_fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_prod  <= '0;
            r_check <= CHECK_INIT;
        end else if (i_end_acc) begin
            r_pos   <= '0;
            r_prod  <= '0;
            r_check <= CHECK_INIT;
        end else begin
            r_check <= w_fold;
            if (i_data_acc) begin
                r_pos  <= n_pos;
                r_prod <= n_prod;
            end else begin
                r_prod <= '0;
            end
        end
    end

endmodule

>>> hw/rtl/c128_emit.sv
// ----------------------------------------------------------------------------
// c128_emit
// Result sequencer: holds one decoded request and sends its start, main and
// stop results, one per cycle unless i_ready stalls the output register.
// ----------------------------------------------------------------------------
module c128_emit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  c128_pkg::t_item i_item,
    output logic        o_can_load,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [12:0] o_pattern,
    output logic [3:0]  o_module_count,
    output logic [2:0]  o_kind,
    output logic        o_last
);
    import c128_pkg::*;

    // slot 0 start, slot 1 main result, slot 2 stop
    logic [2:0]  r_slots;
    logic [6:0]  r_value;
    t_kind       r_main_kind;
    logic [2:0]  w_pick;
    logic [2:0]  w_left;
    logic        w_advance;
    logic        r_out_vld;
    logic [12:0] r_pattern;
    logic [3:0]  r_count;
    t_kind       r_kind;
    logic        r_last;
    logic [12:0] n_pattern;
    logic [3:0]  n_count;
    t_kind       n_kind;

    assign w_advance  = (|r_slots) && (!r_out_vld || i_ready);
    assign w_pick     = r_slots & (~r_slots + 3'd1);
    assign w_left     = r_slots & ~w_pick;
    assign o_can_load = (r_slots == '0) || (w_advance && (w_left == '0));

    always_comb begin
        n_pattern = '0;
        n_count   = '0;
        n_kind    = KIND_REJECT;
        priority if (w_pick[0]) begin
            n_pattern = 13'(symbol_pattern(START_VALUE));
            n_count   = SYMBOL_MODULES;
            n_kind    = KIND_START;
        end else if (w_pick[1]) begin
            n_kind = r_main_kind;
            if (r_main_kind != KIND_REJECT) begin
                n_pattern = 13'(symbol_pattern(r_value));
                n_count   = SYMBOL_MODULES;
            end
        end else begin
            n_pattern = STOP_PATTERN;
            n_count   = STOP_MODULES;
            n_kind    = KIND_STOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_load) begin
                r_slots <= {i_item.has_stop, 1'b1, i_item.need_start};
            end else if (w_advance) begin
                r_slots <= w_left;
            end
            if (w_advance) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value     <= i_item.main_value;
            r_main_kind <= i_item.main_kind;
        end
        if (w_advance) begin
            r_pattern <= n_pattern;
            r_count   <= n_count;
            r_kind    <= n_kind;
            r_last    <= (w_left == '0);
        end
    end

    assign o_valid        = r_out_vld;
    assign o_pattern      = r_pattern;
    assign o_module_count = r_count;
    assign o_kind         = r_kind;
    assign o_last         = r_last;

endmodule

>>> hw/rtl/code128b_module_encoder.sv
// ----------------------------------------------------------------------------
// code128b_module_encoder
// Code 128 set B encoder: characters in, bar/space module patterns out.
//
//   channel  | handshake         | payload
//   ---------+-------------------+------------------------------------------
//   request  | i_valid / o_ready | i_cmd, i_char_code
//   result   | o_valid / i_ready | o_pattern, o_module_count, o_kind, o_last
//
// Each request yields one to three results; the output register sends one
// result per cycle while the result channel is not stalled. A request enters
// while the last result of the one before is sent. A request is held in the
// slot register first, and its results then pass through the output register.
// Reset clears the message state (no start sent, position 0, sum 1).
// A stalled result channel holds the output register and the pending request.
// ----------------------------------------------------------------------------
module code128b_module_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_char_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [12:0] o_pattern,
    output logic [3:0]  o_module_count,
    output logic [2:0]  o_kind,
    output logic        o_last
);
    import c128_pkg::*;

    logic       r_started;
    logic       w_accept;
    logic       w_char_ok;
    logic [6:0] w_value;
    logic [6:0] w_check;
    t_item      w_item;

    assign w_accept  = i_valid && o_ready;
    assign w_char_ok = (i_char_code >= CODE_LOW) && (i_char_code <= CODE_HIGH);
    assign w_value   = 7'(i_char_code - CODE_LOW);

    always_comb begin
        w_item.need_start = !r_started;
        w_item.has_stop   = i_cmd;
        if (i_cmd) begin
            w_item.main_kind  = KIND_CHECK;
            w_item.main_value = w_check;
        end else begin
            w_item.main_kind  = w_char_ok ? KIND_DATA : KIND_REJECT;
            w_item.main_value = w_value;
        end
    end

    // end of message returns to the no-start state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
        end else if (w_accept) begin
            r_started <= !i_cmd;
        end
    end

    c128_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data_acc (w_accept && !i_cmd && w_char_ok),
        .i_end_acc  (w_accept && i_cmd),
        .i_value    (w_value),
        .o_check    (w_check)
    );

    c128_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_accept),
        .i_item         (w_item),
        .o_can_load     (o_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pattern      (o_pattern),
        .o_module_count (o_module_count),
        .o_kind         (o_kind),
        .o_last         (o_last)
    );

endmodule

>>> hw/rtl/c128_checker.sv
// ----------------------------------------------------------------------------
// c128_checker
// Port-level checks of the encoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module c128_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [12:0] o_pattern,
    input logic [3:0]  o_module_count,
    input logic [2:0]  o_kind,
    input logic        o_last
);
    import c128_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pattern) && $stable(o_kind))
        else $error("stalled result changed");

    a_stop_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_STOP) |->
            (o_module_count == STOP_MODULES) && (o_pattern == STOP_PATTERN) && o_last)
        else $error("stop result malformed");

    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_REJECT) |-> (o_module_count == 4'd0) && (o_pattern == '0))
        else $error("rejected result carries modules");

    a_start_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_START) |-> !o_last && (o_module_count == SYMBOL_MODULES))
        else $error("start result ends a request");

    a_check_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && (o_kind == KIND_CHECK) |=> o_valid && (o_kind == KIND_STOP))
        else $error("check not followed by stop");

endmodule

bind code128b_module_encoder c128_checker u_c128_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_pattern      (o_pattern),
    .o_module_count (o_module_count),
    .o_kind         (o_kind),
    .o_last         (o_last)
);
